@@ rtl/core/imh_pkg.sv @@
package imh_pkg;

  localparam int unsigned CapacityDefault = 256;
  localparam int unsigned KeyBitsDefault  = 31;
  localparam int unsigned HandleBits      = 8;
  localparam int unsigned Handles         = 256;
  localparam int unsigned KeyPortBits     = 31;
  localparam int unsigned TotalBits       = 9;

  typedef enum logic [1:0] {
    OpPush   = 2'd0,
    OpRemove = 2'd1,
    OpPop    = 2'd2,
    OpNone   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StFull    = 2'd1,
    StEmpty   = 2'd2,
    StPresent = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]             operation;
    logic [HandleBits-1:0]  handle;
    logic [KeyPortBits-1:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [HandleBits-1:0]  removed_handle;
    logic [KeyPortBits-1:0] removed_key;
    logic                   top_valid;
    logic [HandleBits-1:0]  top_handle;
    logic [KeyPortBits-1:0] top_key;
    logic [TotalBits-1:0]   entry_total;
  } rsp_t;

  // datapath commands
  typedef enum logic [3:0] {
    CmdNop     = 4'd0,
    CmdLatch   = 4'd1,
    CmdPosRd   = 4'd2,
    CmdCheck   = 4'd3,
    CmdPush    = 4'd4,
    CmdRdGap   = 4'd5,
    CmdFill    = 4'd6,
    CmdRdPar   = 4'd7,
    CmdUpSwap  = 4'd8,
    CmdRdKids  = 4'd9,
    CmdDnSwap  = 4'd10,
    CmdRdTop   = 4'd11,
    CmdRdCur   = 4'd12
  } cmd_e;

  typedef struct packed {
    logic clr_done;
    logic fail;
    logic is_push;
    logic gap_is_last;
    logic up_go;
    logic up_at_root;
    logic dn_go;
    logic dn_leaf;
  } stat_t;

endpackage

@@ rtl/core/imh_datapath.sv @@
module imh_datapath #(
  parameter int unsigned Capacity = imh_pkg::CapacityDefault,
  parameter int unsigned KeyBits  = imh_pkg::KeyBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  imh_pkg::req_t req_i,
  input  imh_pkg::cmd_e cmd_i,
  output imh_pkg::stat_t stat_o,
  output imh_pkg::rsp_t rsp_o
);
  localparam int unsigned PW = $clog2(Capacity + 1);
  localparam int unsigned AW = $clog2(Capacity + 1);
  localparam int unsigned HB = imh_pkg::HandleBits;
  localparam int unsigned KP = imh_pkg::KeyPortBits;
  localparam int unsigned TB = imh_pkg::TotalBits;

  // slot memories, index 1..Capacity
  logic [HB-1:0]      mem_h [Capacity+1];
  logic [KeyBits-1:0] mem_k [Capacity+1];
  // position map, also a memory; reset by clearing pass (flag below)
  logic [PW-1:0]      pos_mem [imh_pkg::Handles];
  logic [HB:0]        clr_q;

  logic [1:0]         op_q;
  logic [HB-1:0]      h_q;
  logic [KeyBits-1:0] k_q;
  logic [PW-1:0]      cnt_q, cnt_d;
  logic [AW-1:0]      p_q, p_d;
  logic [PW-1:0]      pos_rd_q;
  logic [HB-1:0]      ah_q, bh_q, ch_q, rh_q;
  logic [KeyBits-1:0] ak_q, bk_q, ck_q, rk_q;
  logic [1:0]         st_q;
  logic               present, fail_c;

  // port address muxes
  logic [AW-1:0]      ra_a, ra_b, wa_a, wa_b;
  logic               we_a, we_b;
  logic [HB-1:0]      wh_a, wh_b;
  logic [KeyBits-1:0] wk_a, wk_b;
  logic               pw_a, pw_b;
  logic [HB-1:0]      pa_a, pa_b, pra;
  logic [PW-1:0]      pd_a, pd_b;
  logic [AW:0]        lidx;
  logic               l_ok, r_ok;
  logic [AW-1:0]      pick;
  logic               dn_go, up_go;

  assign present = (pos_rd_q != '0) && (pos_rd_q <= cnt_q);
  assign lidx    = {p_q, 1'b0};
  assign l_ok    = lidx <= (AW+1)'(cnt_q);
  assign r_ok    = (lidx + 1'b1) <= (AW+1)'(cnt_q);
  assign up_go   = (p_q > AW'(1)) && (ak_q < ck_q);

  always_comb begin
    dn_go = 1'b0;
    pick  = lidx[AW-1:0];
    if (r_ok) begin
      if (ak_q > ck_q && ak_q >= bk_q) dn_go = 1'b1;
      else if (bk_q > ck_q && bk_q > ak_q) begin
        dn_go = 1'b1;
        pick  = AW'(lidx + 1'b1);
      end
    end else if (l_ok && ak_q > ck_q) dn_go = 1'b1;
  end

  always_comb begin
    fail_c = 1'b0;
    case (op_q)
      imh_pkg::OpPush:   fail_c = present || (cnt_q >= PW'(Capacity));
      imh_pkg::OpRemove: fail_c = !present;
      imh_pkg::OpPop:    fail_c = (cnt_q == '0);
      default:           fail_c = 1'b1;
    endcase
  end

  assign stat_o.clr_done    = clr_q[HB];
  assign stat_o.fail        = fail_c;
  assign stat_o.is_push     = (op_q == imh_pkg::OpPush);
  assign stat_o.gap_is_last = (p_q == AW'(cnt_q));
  assign stat_o.up_go       = up_go;
  assign stat_o.up_at_root  = (p_q <= AW'(1));
  assign stat_o.dn_go       = dn_go;
  assign stat_o.dn_leaf     = !l_ok;

  // memory port control
  always_comb begin
    ra_a = p_q; ra_b = p_q;
    we_a = 1'b0; we_b = 1'b0;
    wa_a = p_q; wa_b = p_q;
    wh_a = h_q; wk_a = k_q; wh_b = ch_q; wk_b = ck_q;
    pw_a = 1'b0; pw_b = 1'b0;
    pa_a = h_q; pa_b = ch_q; pd_a = '0; pd_b = PW'(p_q);
    pra  = h_q;
    case (cmd_i)
      imh_pkg::CmdPush: begin
        we_a = 1'b1; wa_a = AW'(cnt_q + 1'b1);
        pw_a = 1'b1; pd_a = PW'(cnt_q + 1'b1);
      end
      imh_pkg::CmdRdGap: begin
        ra_a = p_q; ra_b = AW'(cnt_q);
      end
      imh_pkg::CmdFill: begin
        // gap handle absent; unless the gap is the last slot, the last entry moves into the gap
        pw_a = 1'b1; pa_a = ah_q; pd_a = '0;
        if (p_q != AW'(cnt_q)) begin
          we_a = 1'b1; wa_a = p_q; wh_a = bh_q; wk_a = bk_q;
          pw_b = 1'b1; pa_b = bh_q; pd_b = PW'(p_q);
        end
      end
      imh_pkg::CmdRdPar: ra_a = p_q >> 1;
      imh_pkg::CmdUpSwap: begin
        we_a = 1'b1; wa_a = p_q >> 1; wh_a = ch_q; wk_a = ck_q;
        we_b = 1'b1; wa_b = p_q; wh_b = ah_q; wk_b = ak_q;
        pw_a = 1'b1; pa_a = ch_q; pd_a = PW'(p_q >> 1);
        pw_b = 1'b1; pa_b = ah_q; pd_b = PW'(p_q);
      end
      imh_pkg::CmdRdKids: begin
        ra_a = lidx[AW-1:0]; ra_b = AW'(lidx + 1'b1);
      end
      imh_pkg::CmdDnSwap: begin
        we_a = 1'b1; wa_a = pick; wh_a = ch_q; wk_a = ck_q;
        we_b = 1'b1; wa_b = p_q;
        wh_b = (pick == lidx[AW-1:0]) ? ah_q : bh_q;
        wk_b = (pick == lidx[AW-1:0]) ? ak_q : bk_q;
        pw_a = 1'b1; pa_a = ch_q; pd_a = PW'(pick);
        pw_b = 1'b1; pa_b = wh_b; pd_b = PW'(p_q);
      end
      imh_pkg::CmdRdTop: begin ra_a = AW'(1); ra_b = AW'(1); end
      imh_pkg::CmdRdCur: begin ra_a = p_q; ra_b = p_q; end
      default: ;
    endcase
    if (clr_q[HB] == 1'b0) begin
      pw_a = 1'b1; pa_a = clr_q[HB-1:0]; pd_a = '0; pw_b = 1'b0;
    end
  end

  logic [HB-1:0]      rd_ha, rd_hb;
  logic [KeyBits-1:0] rd_ka, rd_kb;
  logic [PW-1:0]      rd_p;

  always_ff @(posedge clk_i) begin
    if (we_a) begin mem_h[wa_a] <= wh_a; mem_k[wa_a] <= wk_a; end
    if (we_b) begin mem_h[wa_b] <= wh_b; mem_k[wa_b] <= wk_b; end
    rd_ha <= mem_h[ra_a]; rd_ka <= mem_k[ra_a];
    rd_hb <= mem_h[ra_b]; rd_kb <= mem_k[ra_b];
    if (pw_a) pos_mem[pa_a] <= pd_a;
    if (pw_b) pos_mem[pa_b] <= pd_b;
    rd_p <= pos_mem[pra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (clr_q[HB] == 1'b0) clr_q <= clr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  // registers that move with the commands
  always_comb begin
    cnt_d = cnt_q;
    p_d   = p_q;
    case (cmd_i)
      imh_pkg::CmdPush: begin cnt_d = cnt_q + 1'b1; p_d = AW'(cnt_q + 1'b1); end
      imh_pkg::CmdCheck: p_d = (op_q == imh_pkg::OpPop) ? AW'(1) : AW'(pos_rd_q);
      imh_pkg::CmdFill:  cnt_d = cnt_q - 1'b1;
      imh_pkg::CmdUpSwap: p_d = p_q >> 1;
      imh_pkg::CmdDnSwap: p_d = pick;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    case (cmd_i)
      imh_pkg::CmdLatch: begin
        op_q <= req_i.operation; h_q <= req_i.handle;
        k_q  <= KeyBits'(req_i.key);
        rh_q <= '0; rk_q <= '0;
      end
      imh_pkg::CmdCheck: begin
        if (!fail_c) st_q <= 2'(imh_pkg::StOk);
        else begin
          case (op_q)
            imh_pkg::OpPush:
              st_q <= present ? 2'(imh_pkg::StPresent) : 2'(imh_pkg::StFull);
            imh_pkg::OpRemove: st_q <= 2'(imh_pkg::StPresent);
            imh_pkg::OpPop:    st_q <= 2'(imh_pkg::StEmpty);
            default:           st_q <= 2'(imh_pkg::StOk);
          endcase
        end
      end
      imh_pkg::CmdFill: begin
        rh_q <= ah_q; rk_q <= ak_q;
        ch_q <= bh_q; ck_q <= bk_q;
      end
      imh_pkg::CmdPush: begin ch_q <= h_q; ck_q <= k_q; end
      imh_pkg::CmdRdCur: ;
      default: ;
    endcase
  end

  // read data is registered at the memory outputs, then taken into the operand registers via prev_cmd_q
  imh_pkg::cmd_e prev_cmd_q;
  always_ff @(posedge clk_i) begin
    prev_cmd_q <= cmd_i;
    case (prev_cmd_q)
      imh_pkg::CmdPosRd:  pos_rd_q <= rd_p;
      imh_pkg::CmdRdGap: begin
        ah_q <= rd_ha; ak_q <= rd_ka; bh_q <= rd_hb; bk_q <= rd_kb;
      end
      imh_pkg::CmdRdPar:  begin ah_q <= rd_ha; ak_q <= rd_ka; end
      imh_pkg::CmdRdKids: begin
        ah_q <= rd_ha; ak_q <= rd_ka; bh_q <= rd_hb; bk_q <= rd_kb;
      end
      imh_pkg::CmdRdTop:  begin ah_q <= rd_ha; ak_q <= rd_ka; end
      default: ;
    endcase
  end

  assign rsp_o.status         = st_q;
  assign rsp_o.removed_handle = rh_q;
  assign rsp_o.removed_key    = KP'(rk_q);
  assign rsp_o.top_valid      = (cnt_q != '0);
  assign rsp_o.top_handle     = (cnt_q != '0) ? ah_q : '0;
  assign rsp_o.top_key        = (cnt_q != '0) ? KP'(ak_q) : '0;
  assign rsp_o.entry_total    = TB'(cnt_q);
endmodule

@@ rtl/core/imh_ctrl.sv @@
module imh_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  imh_pkg::stat_t stat_i,
  output imh_pkg::cmd_e  cmd_o,
  output logic           busy_o,
  output logic           done_o
);
  typedef enum logic [15:0] {
    SIdle  = 16'b0000000000000001,
    SPos   = 16'b0000000000000010,
    SPosW  = 16'b0000000000000100,
    SCheck = 16'b0000000000001000,
    SGap   = 16'b0000000000010000,
    SGapW  = 16'b0000000000100000,
    SFill  = 16'b0000000001000000,
    SPar   = 16'b0000000010000000,
    SParW  = 16'b0000000100000000,
    SUp    = 16'b0000001000000000,
    SKids  = 16'b0000010000000000,
    SKidsW = 16'b0000100000000000,
    SDn    = 16'b0001000000000000,
    STop   = 16'b0010000000000000,
    STopW  = 16'b0100000000000000,
    SDone  = 16'b1000000000000000
  } state_e;

  state_e state_q, state_d;

  assign busy_o = (state_q != SIdle) || !stat_i.clr_done;

  always_comb begin
    state_d = state_q;
    cmd_o   = imh_pkg::CmdNop;
    done_o  = 1'b0;
    case (state_q)
      SIdle: begin
        if (start_i && stat_i.clr_done) begin
          cmd_o = imh_pkg::CmdLatch; state_d = SPos;
        end
      end
      SPos:   begin cmd_o = imh_pkg::CmdPosRd; state_d = SPosW; end
      SPosW:  state_d = SCheck;
      SCheck: begin
        cmd_o   = imh_pkg::CmdCheck;
        state_d = stat_i.fail ? STop : SGap;
      end
      SGap: begin
        if (stat_i.is_push) begin cmd_o = imh_pkg::CmdPush; state_d = SPar; end
        else begin cmd_o = imh_pkg::CmdRdGap; state_d = SGapW; end
      end
      SGapW:  state_d = SFill;
      SFill: begin
        cmd_o   = imh_pkg::CmdFill;
        state_d = stat_i.gap_is_last ? STop : SPar;
      end
      SPar: begin
        if (stat_i.up_at_root) state_d = stat_i.is_push ? STop : SKids;
        else begin cmd_o = imh_pkg::CmdRdPar; state_d = SParW; end
      end
      SParW: state_d = SUp;
      SUp: begin
        if (stat_i.up_go) begin cmd_o = imh_pkg::CmdUpSwap; state_d = SPar; end
        else state_d = stat_i.is_push ? STop : SKids;
      end
      SKids: begin
        if (stat_i.dn_leaf) state_d = STop;
        else begin cmd_o = imh_pkg::CmdRdKids; state_d = SKidsW; end
      end
      SKidsW: state_d = SDn;
      SDn: begin
        if (stat_i.dn_go) begin cmd_o = imh_pkg::CmdDnSwap; state_d = SKids; end
        else state_d = STop;
      end
      STop:  begin cmd_o = imh_pkg::CmdRdTop; state_d = STopW; end
      STopW: state_d = SDone;
      SDone: begin done_o = 1'b1; state_d = SIdle; end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

@@ rtl/core/indexed_max_heap.sv @@
// sequence: a rejected or no-op beat goes from the check straight to reading the top; removing
//   the last slot does so after the fill; any other beat sifts up or down a level at a time
// one beat at a time: busy stays high from accept until done_o
// each level costs a slot read, a wait for the registered data and a two-port swap
// reset: asynchronous active low; a clearing pass then zeroes every position map entry, busy high
// results appear on done_o for one cycle; the receiver cannot stall
module indexed_max_heap #(
  parameter int unsigned Capacity = imh_pkg::CapacityDefault,
  parameter int unsigned KeyBits  = imh_pkg::KeyBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  imh_pkg::req_t req_i,
  output logic          done_o,
  output imh_pkg::rsp_t rsp_o
);
  // controller sequences commands, datapath owns memories and compares
  imh_pkg::cmd_e  cmd;
  imh_pkg::stat_t stat;

  imh_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start),
    .stat_i(stat), .cmd_o(cmd), .busy_o(busy), .done_o
  );

  imh_datapath #(.Capacity(Capacity), .KeyBits(KeyBits)) u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .stat_o(stat), .rsp_o
  );
endmodule

@@ rtl/core/imh_checker.sv @@
module imh_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input imh_pkg::rsp_t rsp_o
);
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.entry_total <= 9'd256) else $error("count out of range");
  a_top_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.top_valid == (rsp_o.entry_total != 9'd0)) else $error("top valid");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("done while idle");
  a_no_done_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("double result");
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted beat not taken");
endmodule

bind indexed_max_heap imh_checker u_imh_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .rsp_o
);
